// File: rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared sizes, register indexes and the queue entry type of the Life
// generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // column index into the line stores
    localparam int COL_W = $clog2(MAX_COLS);
    // grid dimension registers and row counter
    localparam int DIM_W = 11;

    localparam int MIN_DIM = 3;

    localparam logic [DIM_W-1:0] GRID_COLS_RST = DIM_W'(800);
    localparam logic [DIM_W-1:0] GRID_ROWS_RST = DIM_W'(600);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

    // queue between the window builder and the rule stage
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int WIN_W = 9;

    // window bit k*3+t: column k (0 left .. 2 right), row t (0 top .. 2 bottom)
    typedef struct packed {
        logic             last;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
        logic [WIN_W-1:0] win;
    } lgs_entry_t;

endpackage

// File: rtl/core/life_generation_stencil.sv
`timescale 1ns / 1ps
// a result passes through the beat register, the queue and the result register before it is on m_tvalid
// throughput: one cell per clock while the result queue has room; the first grid_cols+1 beats of a frame give no result
// each window step reads one column from the line stores and then writes it back
// reset: synchronous, active low; clears position, window, queue and result register
// line stores are not cleared; grid_cols and grid_rows return to 800 and 600
// ----------------------------------------------------------------------------
// life_generation_stencil
// Streaming next-generation engine for Life rule B3/S23 over a raster grid.
// ----------------------------------------------------------------------------
module life_generation_stencil (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgs_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] cell_req, [7:1] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] next_cell, [7:1] zero
    output logic                          m_tlast    // last_cell
);
    import lgs_pkg::*;

    logic [DIM_W-1:0]   grid_cols_reg, grid_rows_reg;
    logic [DIM_W-1:0]   cols, rows;
    logic               push, pop, q_valid;
    lgs_entry_t         push_data, q_data;
    logic [Q_CNT_W-1:0] q_count;
    logic               next_cell;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= GRID_COLS_RST;
            grid_rows_reg <= GRID_ROWS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate dimensions to the supported range
    always_comb begin
        if (grid_cols_reg < DIM_W'(MIN_DIM)) begin
            cols = DIM_W'(MIN_DIM);
        end else if (grid_cols_reg > DIM_W'(MAX_COLS)) begin
            cols = DIM_W'(MAX_COLS);
        end else begin
            cols = grid_cols_reg;
        end
        if (grid_rows_reg < DIM_W'(MIN_DIM)) begin
            rows = DIM_W'(MIN_DIM);
        end else if (grid_rows_reg > DIM_W'(MAX_ROWS)) begin
            rows = DIM_W'(MAX_ROWS);
        end else begin
            rows = grid_rows_reg;
        end
    end

    lgs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cols      (cols),
        .rows      (rows),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_cell    (s_tdata[0]),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    lgs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_count   (q_count)
    );

    lgs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .next_cell (next_cell),
        .last_cell (m_tlast)
    );

    assign m_tdata = {7'b0000000, next_cell};

endmodule

// File: rtl/core/lgs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_fifo
// Short register queue of window entries between front and back.
// ----------------------------------------------------------------------------
module lgs_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  lgs_pkg::lgs_entry_t         push_data,
    input  logic                        pop,
    output logic                        q_valid,
    output lgs_pkg::lgs_entry_t         q_data,
    output logic [lgs_pkg::Q_CNT_W-1:0] q_count
);
    import lgs_pkg::*;

    lgs_entry_t         slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_pop;

    assign q_valid = (count_reg != '0);
    assign q_data  = slot_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/lgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_front
// Raster position tracking, line stores and 3x3 window; classifies each cell
// beat and queues the windows that produce a result.
// ----------------------------------------------------------------------------
module lgs_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lgs_pkg::DIM_W-1:0]   cols,
    input  logic [lgs_pkg::DIM_W-1:0]   rows,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_cell,
    input  logic [lgs_pkg::Q_CNT_W-1:0] q_count,
    output logic                        push,
    output lgs_pkg::lgs_entry_t         push_data
);
    import lgs_pkg::*;

    // raster position
    logic [COL_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;

    // beat in flight between line store read and write
    logic             p_valid_reg;
    logic [COL_W-1:0] p_col_reg;
    logic             p_cell_reg;
    logic             p_emit_reg;
    logic             p_last_reg;
    logic             p_top_reg, p_bottom_reg, p_left_reg, p_right_reg;

    logic [WIN_W-1:0] window_reg, window_next;

    logic             line_above [MAX_COLS];
    logic             line_middle [MAX_COLS];
    logic             rd_above_reg, rd_mid_reg;
    logic             fwd_hit_reg, fwd_above_reg, fwd_mid_reg;
    logic             above_q, mid_q;

    logic             accept;
    logic             restart;
    logic [COL_W-1:0] c_sel;
    logic [DIM_W-1:0] r_sel;
    logic [DIM_W-1:0] rows_p1;
    logic [DIM_W-1:0] c_inc;
    logic             cur_cell;
    logic             last;
    logic             emit;
    logic [2:0]       column;

    // room for this beat and the one already past the read
    assign s_tready = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, p_valid_reg})
                      < (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        rows_p1  = rows + 1'b1;
        restart  = ({1'b0, col_reg} >= cols) || (row_reg > rows_p1) ||
                   ((row_reg == rows_p1) && (col_reg != '0));
        c_sel    = restart ? '0 : col_reg;
        r_sel    = restart ? '0 : row_reg;
        cur_cell = (r_sel < rows) ? s_cell : 1'b0;
        last     = (r_sel == rows_p1);
        c_inc    = {1'b0, c_sel} + 1'b1;
        emit     = ((r_sel >= DIM_W'(1)) && (c_sel != '0)) || (r_sel >= DIM_W'(2));

        if (c_inc >= cols) begin
            col_next = '0;
            row_next = r_sel + 1'b1;
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_sel;
        end
        if (last) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            p_valid_reg <= 1'b0;
            window_reg  <= '0;
        end else begin
            p_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (p_valid_reg) begin
                window_reg <= window_next;
            end
        end
    end

    // edge classification of the output cell, one row and one column behind
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_col_reg  <= c_sel;
            p_cell_reg <= cur_cell;
            p_emit_reg <= emit;
            p_last_reg <= last;
            if (c_sel == '0) begin
                p_top_reg    <= (r_sel == DIM_W'(2));
                p_bottom_reg <= last;
                p_left_reg   <= 1'b0;
                p_right_reg  <= 1'b1;
            end else begin
                p_top_reg    <= (r_sel == DIM_W'(1));
                p_bottom_reg <= (r_sel == rows);
                p_left_reg   <= (c_sel == COL_W'(1));
                p_right_reg  <= 1'b0;
            end
        end
    end

    // line stores: read at accept, written in the following cycle
    always_ff @(posedge aclk) begin
        if (p_valid_reg) begin
            line_above[p_col_reg]  <= mid_q;
            line_middle[p_col_reg] <= p_cell_reg;
        end
        rd_above_reg <= line_above[c_sel];
        rd_mid_reg   <= line_middle[c_sel];
    end

    // bypass a write landing on the address being read
    always_ff @(posedge aclk) begin
        fwd_hit_reg   <= p_valid_reg && (p_col_reg == c_sel);
        fwd_above_reg <= mid_q;
        fwd_mid_reg   <= p_cell_reg;
    end

    assign above_q = fwd_hit_reg ? fwd_above_reg : rd_above_reg;
    assign mid_q   = fwd_hit_reg ? fwd_mid_reg : rd_mid_reg;

    always_comb begin
        column      = {p_cell_reg, mid_q, above_q};
        window_next = {column, window_reg[WIN_W-1:3]};
    end

    assign push             = p_valid_reg && p_emit_reg;
    assign push_data.last   = p_last_reg;
    assign push_data.top    = p_top_reg;
    assign push_data.bottom = p_bottom_reg;
    assign push_data.left   = p_left_reg;
    assign push_data.right  = p_right_reg;
    assign push_data.win    = window_next;

endmodule

// File: rtl/core/lgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_back
// Edge masking, neighbor count and B3/S23 rule; drives the result register.
// ----------------------------------------------------------------------------
module lgs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  lgs_pkg::lgs_entry_t q_data,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                next_cell,
    output logic                last_cell
);
    import lgs_pkg::*;

    localparam logic [WIN_W-1:0] CENTER_MASK = 9'h010;
    localparam logic [WIN_W-1:0] TOP_MASK    = 9'h049;
    localparam logic [WIN_W-1:0] BOTTOM_MASK = 9'h124;
    localparam logic [WIN_W-1:0] LEFT_MASK   = 9'h007;
    localparam logic [WIN_W-1:0] RIGHT_MASK  = 9'h1C0;

    logic             m_tvalid_reg;
    logic             next_reg;
    logic             last_reg;
    logic [WIN_W-1:0] nb;
    logic [3:0]       cnt;
    logic             center;
    logic             nxt;

    assign pop = q_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        nb = q_data.win & ~CENTER_MASK;
        if (q_data.top)    nb = nb & ~TOP_MASK;
        if (q_data.bottom) nb = nb & ~BOTTOM_MASK;
        if (q_data.left)   nb = nb & ~LEFT_MASK;
        if (q_data.right)  nb = nb & ~RIGHT_MASK;
        cnt = '0;
        for (int i = 0; i < WIN_W; i++) begin
            cnt = cnt + {3'b000, nb[i]};
        end
        center = q_data.win[4];
        if (cnt == 4'd3) begin
            nxt = 1'b1;
        end else if (cnt == 4'd2) begin
            nxt = center;
        end else begin
            nxt = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            next_reg <= nxt;
            last_reg <= q_data.last;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign next_cell = next_reg;
    assign last_cell = last_reg;

endmodule

// File: rtl/core/lgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the stencil's result channel and reset behavior.
// ----------------------------------------------------------------------------
module lgs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled result beat stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'b0000000))
        else $error("result padding bits set");

    // a fresh result follows an accepted cell beat
    a_rise_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result beat without a matching cell beat");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
